@@ hw/rtl/pba_pkg.sv @@
// Shared types, constants and helper functions of the paired page allocator.
package pba_pkg;

    localparam int SLOTS       = 256;
    localparam int SLOT_W      = 8;
    localparam int LINK_W      = 9;
    localparam int NCHUNKS     = 64;
    localparam int BIN_W       = 6;
    localparam int CHUNK_W     = 7;
    localparam int CHUNK_LOG2  = 6;
    localparam int SIZE_W      = 13;
    localparam int PAGE_BYTES  = 4096;
    localparam int GROUP_W     = 16;
    localparam int GROUPS      = SLOTS / GROUP_W;

    localparam logic [LINK_W-1:0]  NIL          = LINK_W'(SLOTS);
    localparam logic [CHUNK_W-1:0] CHUNKS_FULL  = CHUNK_W'(NCHUNKS);
    localparam logic [SIZE_W-1:0]  SIZE_MAX     = SIZE_W'(PAGE_BYTES);
    localparam logic [SIZE_W:0]    CHUNK_ROUND  = (SIZE_W+1)'((1 << CHUNK_LOG2) - 1);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOSLOT  = 2'd2
    } status_t;

    typedef struct packed {
        logic [CHUNK_W-1:0] fsz;
        logic [CHUNK_W-1:0] lsz;
        logic [LINK_W-1:0]  bin_nxt;
        logic [LINK_W-1:0]  bin_prv;
        logic [LINK_W-1:0]  rec_nxt;
        logic [LINK_W-1:0]  rec_prv;
    } slot_rec_t;

    typedef struct packed {
        logic              en_size;
        logic              en_bin_nxt;
        logic              en_bin_prv;
        logic              en_rec_nxt;
        logic              en_rec_prv;
        logic [SLOT_W-1:0] addr;
        slot_rec_t         data;
    } slot_wr_t;

    typedef struct packed {
        logic             full;
        logic [BIN_W-1:0] idx;
    } home_t;

    function automatic logic [CHUNK_W-1:0] free_chunks(logic [CHUNK_W-1:0] fsz,
                                                       logic [CHUNK_W-1:0] lsz);
        logic [CHUNK_W:0] used;
        logic [CHUNK_W:0] rem;
        used = {1'b0, fsz} + {1'b0, lsz};
        rem  = (CHUNK_W+1)'(NCHUNKS) - used;
        if (used >= (CHUNK_W+1)'(NCHUNKS))
            return '0;
        return rem[CHUNK_W-1:0];
    endfunction

    function automatic home_t home_of(logic [CHUNK_W-1:0] fsz, logic [CHUNK_W-1:0] lsz);
        home_t h;
        logic [CHUNK_W-1:0] fc;
        fc     = free_chunks(fsz, lsz);
        h.full = (fsz != '0) && (lsz != '0);
        h.idx  = fc[BIN_W-1:0];
        return h;
    endfunction

endpackage

@@ hw/rtl/paired_buddy_page_allocator.sv @@
// Top level: request sequencer, bin head memory and pool bookkeeping.
// A request's time from the accepting edge to the edge that takes the result is set by the
// sequencer that walks the slot record memory one list link at a time (one read or masked
// write per step); a bad request or a free of an unused slot goes straight to the result.
// busy drops in the cycle the result shows, so the next request can be accepted at the edge
// that takes it; the result shows for one cycle with done high and must be taken then. No
// clearing pass follows reset.
module paired_buddy_page_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            op,
    input  logic [pba_pkg::SIZE_W-1:0]      size_bytes,
    input  logic                            highmem_request,
    input  logic [pba_pkg::SLOT_W-1:0]      free_slot,
    input  logic [5:0]                      free_offset,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [pba_pkg::SLOT_W-1:0]      slot_out,
    output logic [5:0]                      offset_out,
    output logic [pba_pkg::LINK_W-1:0]      pages_in_use
);
    import pba_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_RECENT = 17'h00002,
        S_SCAN   = 17'h00004,
        S_BINHD  = 17'h00008,
        S_LOAD   = 17'h00010,
        S_UB1    = 17'h00020,
        S_UB2    = 17'h00040,
        S_SETSZ  = 17'h00080,
        S_PB1    = 17'h00100,
        S_PB2    = 17'h00200,
        S_PB3    = 17'h00400,
        S_PB4    = 17'h00800,
        S_UR1    = 17'h01000,
        S_UR2    = 17'h02000,
        S_PR1    = 17'h04000,
        S_PR2    = 17'h08000,
        S_DONE   = 17'h10000
    } state_t;

    state_t              state_reg, state_next;
    logic                op_reg, op_next;
    logic                off_nz_reg, off_nz_next;
    logic                last_reg, last_next;
    logic                fresh_reg, fresh_next;
    logic [CHUNK_W-1:0]  chunks_reg, chunks_next;
    logic [SLOT_W-1:0]   s_reg, s_next;
    logic [LINK_W-1:0]   hv_reg, hv_next;
    slot_rec_t           cur_reg, cur_next;
    status_t             code_reg, code_next;
    logic [LINK_W-1:0]   recent_head_reg, recent_head_next;
    logic [LINK_W-1:0]   full_head_reg, full_head_next;
    logic [LINK_W-1:0]   page_total_reg, page_total_next;
    logic [SLOTS-1:0]    busy_reg, busy_next;
    logic [NCHUNKS-1:0]  nonempty_reg;
    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;
    logic [SLOT_W-1:0]   slot_out_reg, slot_out_next;
    logic [5:0]          off_out_reg, off_out_next;
    logic [LINK_W-1:0]   pages_reg, pages_next;

    // bin heads
    logic [LINK_W-1:0]   bin_mem [NCHUNKS];
    logic                bin_wr_en;
    logic [BIN_W-1:0]    bin_wr_addr;
    logic [LINK_W-1:0]   bin_wr_data;
    logic                bin_rd_en;
    logic [BIN_W-1:0]    bin_rd_addr;
    logic [LINK_W-1:0]   bin_rd_data;
    logic                bin_rd_valid;

    logic                sm_rd_en;
    logic [SLOT_W-1:0]   sm_rd_addr;
    slot_rec_t           sm_rd_data;
    slot_wr_t            sm_wr;

    logic                ff_found;
    logic [SLOT_W-1:0]   ff_idx;

    logic                scan_found;
    logic [BIN_W-1:0]    scan_idx;
    home_t               home_cur;
    logic [SIZE_W:0]     size_round;
    logic [CHUNK_W-1:0]  req_chunks;
    logic [CHUNK_W-1:0]  rd_fc;
    logic [CHUNK_W-1:0]  new_fsz, new_lsz;

    pba_slot_mem u_slot_mem (
        .clk     (clk),
        .rd_en   (sm_rd_en),
        .rd_addr (sm_rd_addr),
        .rd_data (sm_rd_data),
        .wr      (sm_wr)
    );

    pba_free_finder u_free_finder (
        .clk       (clk),
        .rst_n     (rst_n),
        .busy_bits (busy_reg),
        .found     (ff_found),
        .idx       (ff_idx)
    );

    always_ff @(posedge clk)
    begin
        if (bin_wr_en)
            bin_mem[bin_wr_addr] <= bin_wr_data;
        if (bin_rd_en)
        begin
            bin_rd_data  <= bin_mem[bin_rd_addr];
            bin_rd_valid <= nonempty_reg[bin_rd_addr];
        end
    end

    assign size_round = {1'b0, size_bytes} + CHUNK_ROUND;
    assign req_chunks = size_round[CHUNK_LOG2 +: CHUNK_W];
    assign home_cur   = home_of(cur_reg.fsz, cur_reg.lsz);
    assign rd_fc      = free_chunks(sm_rd_data.fsz, sm_rd_data.lsz);

    // first non-empty bin at or above the requested chunk count
    always_comb
    begin
        scan_found = 1'b0;
        scan_idx   = '0;
        for (int i = NCHUNKS - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i] && (CHUNK_W'(i) >= chunks_reg))
            begin
                scan_found = 1'b1;
                scan_idx   = BIN_W'(i);
            end
        end
    end

    always_comb
    begin
        new_fsz = cur_reg.fsz;
        new_lsz = cur_reg.lsz;
        if (op_reg == OP_FREE)
        begin
            if (off_nz_reg)
                new_lsz = '0;
            else
                new_fsz = '0;
        end
        else if (last_reg)
            new_lsz = chunks_reg;
        else
            new_fsz = chunks_reg;
    end

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        off_nz_next      = off_nz_reg;
        last_next        = last_reg;
        fresh_next       = fresh_reg;
        chunks_next      = chunks_reg;
        s_next           = s_reg;
        hv_next          = hv_reg;
        cur_next         = cur_reg;
        code_next        = code_reg;
        recent_head_next = recent_head_reg;
        full_head_next   = full_head_reg;
        page_total_next  = page_total_reg;
        busy_next        = busy_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        slot_out_next    = slot_out_reg;
        off_out_next     = off_out_reg;
        pages_next       = pages_reg;
        bin_wr_en        = 1'b0;
        bin_wr_addr      = home_cur.idx;
        bin_wr_data      = NIL;
        bin_rd_en        = 1'b0;
        bin_rd_addr      = home_cur.idx;
        sm_rd_en         = 1'b0;
        sm_rd_addr       = s_reg;
        sm_wr            = '0;
        sm_wr.addr       = s_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    fresh_next = 1'b0;
                    code_next  = ST_OK;
                    if (op == OP_FREE)
                    begin
                        s_next      = free_slot;
                        off_nz_next = (free_offset != '0);
                        if (!busy_reg[free_slot])
                        begin
                            code_next  = ST_INVALID;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            sm_rd_en   = 1'b1;
                            sm_rd_addr = free_slot;
                            state_next = S_LOAD;
                        end
                    end
                    else
                    begin
                        chunks_next = req_chunks;
                        if (size_bytes == '0 || size_bytes > SIZE_MAX || highmem_request)
                        begin
                            code_next  = ST_INVALID;
                            state_next = S_DONE;
                        end
                        else if (recent_head_reg != NIL)
                        begin
                            sm_rd_en   = 1'b1;
                            sm_rd_addr = recent_head_reg[SLOT_W-1:0];
                            s_next     = recent_head_reg[SLOT_W-1:0];
                            state_next = S_RECENT;
                        end
                        else
                            state_next = S_SCAN;
                    end
                end
            end

            S_RECENT:
            begin
                cur_next = sm_rd_data;
                if (rd_fc >= chunks_reg && (sm_rd_data.fsz == '0 || sm_rd_data.lsz == '0))
                begin
                    last_next  = (sm_rd_data.fsz != '0);
                    state_next = S_UB1;
                end
                else
                    state_next = S_SCAN;
            end

            S_SCAN:
            begin
                if (scan_found)
                begin
                    bin_rd_en   = 1'b1;
                    bin_rd_addr = scan_idx;
                    state_next  = S_BINHD;
                end
                else if (ff_found)
                begin
                    s_next            = ff_idx;
                    fresh_next        = 1'b1;
                    last_next         = 1'b0;
                    cur_next.fsz      = '0;
                    cur_next.lsz      = '0;
                    busy_next[ff_idx] = 1'b1;
                    page_total_next   = page_total_reg + 1'b1;
                    state_next        = S_SETSZ;
                end
                else
                begin
                    code_next  = ST_NOSLOT;
                    state_next = S_DONE;
                end
            end

            S_BINHD:
            begin
                s_next     = bin_rd_data[SLOT_W-1:0];
                sm_rd_en   = 1'b1;
                sm_rd_addr = bin_rd_data[SLOT_W-1:0];
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                cur_next   = sm_rd_data;
                last_next  = (sm_rd_data.fsz != '0);
                state_next = S_UB1;
            end

            // drop the slot from its bin: predecessor side
            S_UB1:
            begin
                if (cur_reg.bin_prv == NIL)
                begin
                    if (home_cur.full)
                        full_head_next = cur_reg.bin_nxt;
                    else
                    begin
                        bin_wr_en   = 1'b1;
                        bin_wr_data = cur_reg.bin_nxt;
                    end
                end
                else
                begin
                    sm_wr.en_bin_nxt   = 1'b1;
                    sm_wr.addr         = cur_reg.bin_prv[SLOT_W-1:0];
                    sm_wr.data.bin_nxt = cur_reg.bin_nxt;
                end
                state_next = S_UB2;
            end

            S_UB2:
            begin
                if (cur_reg.bin_nxt != NIL)
                begin
                    sm_wr.en_bin_prv   = 1'b1;
                    sm_wr.addr         = cur_reg.bin_nxt[SLOT_W-1:0];
                    sm_wr.data.bin_prv = cur_reg.bin_prv;
                end
                state_next = S_SETSZ;
            end

            S_SETSZ:
            begin
                cur_next.fsz   = new_fsz;
                cur_next.lsz   = new_lsz;
                sm_wr.en_size  = 1'b1;
                sm_wr.data.fsz = new_fsz;
                sm_wr.data.lsz = new_lsz;
                if (op_reg == OP_FREE && new_fsz == '0 && new_lsz == '0)
                    state_next = S_UR1;
                else
                    state_next = S_PB1;
            end

            S_PB1:
            begin
                if (home_cur.full)
                begin
                    hv_next    = full_head_reg;
                    state_next = S_PB3;
                end
                else
                begin
                    bin_rd_en  = 1'b1;
                    state_next = S_PB2;
                end
            end

            S_PB2:
            begin
                hv_next    = bin_rd_valid ? bin_rd_data : NIL;
                state_next = S_PB3;
            end

            S_PB3:
            begin
                sm_wr.en_bin_nxt   = 1'b1;
                sm_wr.en_bin_prv   = 1'b1;
                sm_wr.data.bin_nxt = hv_reg;
                sm_wr.data.bin_prv = NIL;
                state_next         = S_PB4;
            end

            S_PB4:
            begin
                if (hv_reg != NIL)
                begin
                    sm_wr.en_bin_prv   = 1'b1;
                    sm_wr.addr         = hv_reg[SLOT_W-1:0];
                    sm_wr.data.bin_prv = {1'b0, s_reg};
                end
                if (home_cur.full)
                    full_head_next = {1'b0, s_reg};
                else
                begin
                    bin_wr_en   = 1'b1;
                    bin_wr_data = {1'b0, s_reg};
                end
                if (op_reg == OP_FREE)
                    state_next = S_DONE;
                else if (fresh_reg)
                    state_next = S_PR1;
                else
                    state_next = S_UR1;
            end

            // drop the slot from the recency list
            S_UR1:
            begin
                if (cur_reg.rec_prv == NIL)
                    recent_head_next = cur_reg.rec_nxt;
                else
                begin
                    sm_wr.en_rec_nxt   = 1'b1;
                    sm_wr.addr         = cur_reg.rec_prv[SLOT_W-1:0];
                    sm_wr.data.rec_nxt = cur_reg.rec_nxt;
                end
                state_next = S_UR2;
            end

            S_UR2:
            begin
                if (cur_reg.rec_nxt != NIL)
                begin
                    sm_wr.en_rec_prv   = 1'b1;
                    sm_wr.addr         = cur_reg.rec_nxt[SLOT_W-1:0];
                    sm_wr.data.rec_prv = cur_reg.rec_prv;
                end
                if (op_reg == OP_FREE)
                begin
                    busy_next[s_reg] = 1'b0;
                    page_total_next  = page_total_reg - 1'b1;
                    state_next       = S_DONE;
                end
                else
                    state_next = S_PR1;
            end

            S_PR1:
            begin
                sm_wr.en_rec_nxt   = 1'b1;
                sm_wr.en_rec_prv   = 1'b1;
                sm_wr.data.rec_nxt = recent_head_reg;
                sm_wr.data.rec_prv = NIL;
                hv_next            = recent_head_reg;
                recent_head_next   = {1'b0, s_reg};
                state_next         = S_PR2;
            end

            S_PR2:
            begin
                if (hv_reg != NIL)
                begin
                    sm_wr.en_rec_prv   = 1'b1;
                    sm_wr.addr         = hv_reg[SLOT_W-1:0];
                    sm_wr.data.rec_prv = {1'b0, s_reg};
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                done_next   = 1'b1;
                status_next = code_reg;
                pages_next  = page_total_reg;
                if (code_reg == ST_OK && op_reg == OP_ALLOC)
                begin
                    slot_out_next = s_reg;
                    off_out_next  = last_reg ? 6'(CHUNKS_FULL - chunks_reg) : '0;
                end
                else
                begin
                    slot_out_next = '0;
                    off_out_next  = '0;
                end
                state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            recent_head_reg <= NIL;
            full_head_reg   <= NIL;
            page_total_reg  <= '0;
            busy_reg        <= '0;
            nonempty_reg    <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            recent_head_reg <= recent_head_next;
            full_head_reg   <= full_head_next;
            page_total_reg  <= page_total_next;
            busy_reg        <= busy_next;
            done_reg        <= done_next;
            if (bin_wr_en)
                nonempty_reg[bin_wr_addr] <= (bin_wr_data != NIL);
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        off_nz_reg   <= off_nz_next;
        last_reg     <= last_next;
        fresh_reg    <= fresh_next;
        chunks_reg   <= chunks_next;
        s_reg        <= s_next;
        hv_reg       <= hv_next;
        cur_reg      <= cur_next;
        code_reg     <= code_next;
        status_reg   <= status_next;
        slot_out_reg <= slot_out_next;
        off_out_reg  <= off_out_next;
        pages_reg    <= pages_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign slot_out     = slot_out_reg;
    assign offset_out   = off_out_reg;
    assign pages_in_use = pages_reg;

endmodule

@@ hw/rtl/pba_slot_mem.sv @@
// Per-slot record memory: sizes and list links, one read and one masked write a cycle.
module pba_slot_mem (
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [pba_pkg::SLOT_W-1:0]        rd_addr,
    output pba_pkg::slot_rec_t                rd_data,
    input  pba_pkg::slot_wr_t                 wr
);
    import pba_pkg::*;

    logic [2*CHUNK_W-1:0] size_mem [SLOTS];
    logic [LINK_W-1:0]    bnx_mem  [SLOTS];
    logic [LINK_W-1:0]    bpv_mem  [SLOTS];
    logic [LINK_W-1:0]    rnx_mem  [SLOTS];
    logic [LINK_W-1:0]    rpv_mem  [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.en_size)
            size_mem[wr.addr] <= {wr.data.fsz, wr.data.lsz};
        if (wr.en_bin_nxt)
            bnx_mem[wr.addr] <= wr.data.bin_nxt;
        if (wr.en_bin_prv)
            bpv_mem[wr.addr] <= wr.data.bin_prv;
        if (wr.en_rec_nxt)
            rnx_mem[wr.addr] <= wr.data.rec_nxt;
        if (wr.en_rec_prv)
            rpv_mem[wr.addr] <= wr.data.rec_prv;
        if (rd_en)
        begin
            {rd_data.fsz, rd_data.lsz} <= size_mem[rd_addr];
            rd_data.bin_nxt <= bnx_mem[rd_addr];
            rd_data.bin_prv <= bpv_mem[rd_addr];
            rd_data.rec_nxt <= rnx_mem[rd_addr];
            rd_data.rec_prv <= rpv_mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/pba_free_finder.sv @@
// Lowest unused slot search: registered per-group stage, then a group pick.
module pba_free_finder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pba_pkg::SLOTS-1:0]    busy_bits,
    output logic                         found,
    output logic [pba_pkg::SLOT_W-1:0]   idx
);
    import pba_pkg::*;

    localparam int GIDX_W = $clog2(GROUP_W);
    localparam int GSEL_W = $clog2(GROUPS);

    logic [GROUPS-1:0] gany_reg;
    logic [GROUPS-1:0] gany_next;
    logic [GIDX_W-1:0] gidx_reg  [GROUPS];
    logic [GIDX_W-1:0] gidx_next [GROUPS];

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            gany_next[g] = 1'b0;
            gidx_next[g] = '0;
            for (int b = GROUP_W - 1; b >= 0; b--)
            begin
                if (!busy_bits[g*GROUP_W + b])
                begin
                    gany_next[g] = 1'b1;
                    gidx_next[g] = GIDX_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gany_reg <= '0;
        else
            gany_reg <= gany_next;
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < GROUPS; g++)
            gidx_reg[g] <= gidx_next[g];
    end

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (gany_reg[g])
            begin
                found = 1'b1;
                idx   = {GSEL_W'(g), gidx_reg[g]};
            end
        end
    end

endmodule
